// File: hdl/mlnps_pkg.sv
// ----------------------------------------------------------------------------
// mlnps_pkg : shared types and constants for the note stack
// Opcodes, sequencer states and the structs passed between the top level
// and the stack cells.
// ----------------------------------------------------------------------------
package mlnps_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int NOTE_W          = 7;
  localparam int VEL_W           = 7;
  localparam int TOTAL_W         = 5;

  localparam logic OP_NOTE_OFF = 1'b0;
  localparam logic OP_NOTE_ON  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESULT
  } state_t;

  // Command broadcast to every cell during the execute cycle
  typedef struct packed {
    logic              push;
    logic              remove;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
  } cell_cmd_t;

  // Contents of one cell, also handed to the lower neighbor
  typedef struct packed {
    logic              occ;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
  } cell_data_t;

endpackage

// File: hdl/mlnps_cell.sv
// ----------------------------------------------------------------------------
// mlnps_cell : one entry of the held-note stack
// Holds a note and velocity with an occupied flag. Loads the pushed note when
// it is the first free entry; on removal shifts in the upper neighbor once a
// match was found at or below it.
// ----------------------------------------------------------------------------
module mlnps_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  mlnps_pkg::cell_cmd_t  cmd,
  input  logic                  prev_occ,
  input  mlnps_pkg::cell_data_t up,
  input  logic                  found_in,
  output mlnps_pkg::cell_data_t data,
  output logic                  found_out
);

  logic match;
  logic load_push;
  logic load_shift;

  assign match      = data.occ && (data.note == cmd.note);
  assign found_out  = found_in || match;
  assign load_push  = cmd.push && !data.occ && prev_occ;
  assign load_shift = cmd.remove && found_out;

  // payload has no reset, only entries with occ set are ever read
  always_ff @(posedge clk) begin
    if (rst) begin
      data.occ <= 1'b0;
    end else if (load_push) begin
      data.occ <= 1'b1;
    end else if (load_shift) begin
      data.occ <= up.occ;
    end
    if (load_push) begin
      data.note <= cmd.note;
      data.vel  <= cmd.vel;
    end else if (load_shift) begin
      data.note <= up.note;
      data.vel  <= up.vel;
    end
  end

endmodule

// File: hdl/mono_last_note_priority_stack.sv
// ----------------------------------------------------------------------------
// mono_last_note_priority_stack : last-note-priority note stack, one voice
// Chain of stack cells with a small sequencer and a registered result.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*) takes one note event per item: s_tuser is the opcode
//   (0 note off, 1 note on), s_tdata carries note and velocity.
//   Master channel (m_*) gives exactly one result per event: gate, sounding
//   note and velocity, slide, retrigger and the number of held notes.
//   Each item passes through an execute cycle, in which the cells push or
//   compare-and-shift, and a result cycle, in which the new top entry is
//   selected and the output register loaded; the result is registered.
//   The next item is accepted in that result cycle, so a new item is taken
//   only as the previous one leaves for the output register.
//   Reset (rst, synchronous, active high) empties the stack and drops
//   m_tvalid; no clearing pass is needed.
//   When the receiver stalls, the result holds in the output register and
//   the sequencer waits in its result cycle; s_tready stays low until the
//   output register is free.
// ----------------------------------------------------------------------------
module mono_last_note_priority_stack #(
  parameter int STACK_DEPTH = mlnps_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // slave channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [6:0] note, [13:7] velocity, [15:14] zero
  input  logic        s_tuser,   // [0] opcode
  // master channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [0] gate, [7:1] sounding_note,
                                 // [14:8] sounding_velocity, [15] slide,
                                 // [16] retrigger, [21:17] held_total,
                                 // [23:22] zero
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int NOTE_W = mlnps_pkg::NOTE_W;
  localparam int VEL_W  = mlnps_pkg::VEL_W;

  mlnps_pkg::state_t state, state_next;

  // latched item
  logic              item_op;
  logic [NOTE_W-1:0] item_note;
  logic [VEL_W-1:0]  item_vel;
  logic              legato;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  mlnps_pkg::cell_cmd_t  cmd;
  mlnps_pkg::cell_data_t cells [STACK_DEPTH];
  logic [STACK_DEPTH:0]  found;
  logic [STACK_DEPTH-1:0] occ_vec;

  logic in_fire;
  logic out_free;
  logic load_out;

  logic              res_gate;
  logic [NOTE_W-1:0] res_note;
  logic [VEL_W-1:0]  res_vel;
  logic              res_slide;
  logic              res_retrig;
  logic [NOTE_W-1:0] top_note;
  logic [VEL_W-1:0]  top_vel;
  logic [CNT_W+4:0]  count_ext;

  assign out_free = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  // --- cell chain ------------------------------------------------------------
  assign cmd.push   = (state == mlnps_pkg::S_EXEC) && (item_op == mlnps_pkg::OP_NOTE_ON);
  assign cmd.remove = (state == mlnps_pkg::S_EXEC) && (item_op == mlnps_pkg::OP_NOTE_OFF);
  assign cmd.note   = item_note;
  assign cmd.vel    = item_vel;
  assign found[0]   = 1'b0;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cells
    logic                  prev_occ;
    mlnps_pkg::cell_data_t up;

    if (i == 0) begin : g_bottom
      assign prev_occ = 1'b1;
    end else begin : g_mid
      assign prev_occ = cells[i-1].occ;
    end

    if (i == STACK_DEPTH - 1) begin : g_topmost
      // nothing above the last entry: shift in an empty slot
      assign up.occ  = 1'b0;
      assign up.note = '0;
      assign up.vel  = '0;
    end else begin : g_below
      assign up = cells[i+1];
    end

    mlnps_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .prev_occ  (prev_occ),
      .up        (up),
      .found_in  (found[i]),
      .data      (cells[i]),
      .found_out (found[i+1])
    );

    assign occ_vec[i] = cells[i].occ;
  end

  // --- held count ------------------------------------------------------------
  always_comb begin
    count_next = count;
    if (cmd.push && (count < CNT_W'(STACK_DEPTH))) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.remove && found[STACK_DEPTH]) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // --- sequencer -------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlnps_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load_out   = 1'b0;
    case (state)
      mlnps_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = mlnps_pkg::S_EXEC;
        end
      end
      mlnps_pkg::S_EXEC: begin
        state_next = mlnps_pkg::S_RESULT;
      end
      mlnps_pkg::S_RESULT: begin
        // hold here while the output register is occupied
        if (out_free) begin
          load_out = 1'b1;
          s_tready = 1'b1;
          state_next = s_tvalid ? mlnps_pkg::S_EXEC : mlnps_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mlnps_pkg::S_IDLE;
      end
    endcase
  end

  // capture the item; legato is whether anything was held before the push
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_op   <= s_tuser;
      item_note <= s_tdata[6:0];
      item_vel  <= s_tdata[13:7];
    end
    if (state == mlnps_pkg::S_EXEC) begin
      legato <= (count != '0);
    end
  end

  // --- result ----------------------------------------------------------------
  // top entry: the occupied cell whose upper neighbor is free
  always_comb begin
    top_note = '0;
    top_vel  = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if (cells[i].occ && ((i == STACK_DEPTH - 1) || !occ_vec[(i + 1) % STACK_DEPTH])) begin
        top_note = top_note | cells[i].note;
        top_vel  = top_vel  | cells[i].vel;
      end
    end
  end

  always_comb begin
    if (item_op == mlnps_pkg::OP_NOTE_ON) begin
      // note on always plays the new note
      res_gate   = 1'b1;
      res_note   = item_note;
      res_vel    = item_vel;
      res_slide  = legato;
      res_retrig = !legato;
    end else if (count == '0) begin
      // stack empty: release
      res_gate   = 1'b0;
      res_note   = '0;
      res_vel    = '0;
      res_slide  = 1'b0;
      res_retrig = 1'b0;
    end else begin
      // fall back to the most recent held note
      res_gate   = 1'b1;
      res_note   = top_note;
      res_vel    = top_vel;
      res_slide  = 1'b1;
      res_retrig = 1'b0;
    end
  end

  // held_total shows the count modulo 32
  assign count_ext = {5'b0, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {2'b00, count_ext[4:0], res_retrig, res_slide, res_vel, res_note, res_gate};
    end
  end

  // --- assertions --------------------------------------------------------------
  // held count agrees with the occupied cells
  a_count_occ: assert property (@(posedge clk) disable iff (rst)
    $countones(occ_vec) == int'(count))
    else $error("held count does not match occupied cells");

  // occupied cells form a contiguous run from the bottom
  a_occ_thermo: assert property (@(posedge clk) disable iff (rst)
    ((occ_vec >> 1) & ~occ_vec) == '0)
    else $error("gap in the note stack");

  // a released gate means the stack is empty
  a_gate_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[21:17] == 5'd0))
    else $error("gate dropped with notes still held");

  // the output register is only loaded when free
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("result overwrote a pending item");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for mono_last_note_priority_stack
// Drives note-on / note-off items into the slave stream and checks every
// result on the master stream against a behavioral note stack kept here.
// A short directed run covers the empty, duplicate and full stack cases;
// random phases follow, with and without idle cycles on either side and
// one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = mlnps_pkg::STACK_DEPTH_DEF;
  localparam int NOTE_W      = mlnps_pkg::NOTE_W;
  localparam int VEL_W       = mlnps_pkg::VEL_W;
  localparam int TOTAL_W     = mlnps_pkg::TOTAL_W;
  localparam int PHASE_ITEMS = 350;
  localparam int HOLD_LEN    = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 8;

  // Traffic phases: who idles and how often
  typedef enum logic [2:0] {
    PH_FREE,
    PH_SRC_IDLE,
    PH_SINK_STALL,
    PH_BOTH_IDLE,
    PH_HOLD
  } phase_t;

  typedef struct {
    logic              op;
    logic [NOTE_W-1:0] key;
    logic [VEL_W-1:0]  vel;
    phase_t            ph;
  } note_event_t;

  typedef struct packed {
    logic               gate;
    logic [NOTE_W-1:0]  key;
    logic [VEL_W-1:0]   vel;
    logic               slide;
    logic               retrig;
    logic [TOTAL_W-1:0] held;
  } voice_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  note_event_t   pending_events[$];
  voice_result_t expected_voice[$];
  logic [NOTE_W-1:0] gen_held[$];   // rough copy of held notes, steers note-offs

  // Behavioral note stack
  logic [NOTE_W-1:0] stack_key[DEPTH];
  logic [VEL_W-1:0]  stack_vel[DEPTH];
  int                stack_cnt = 0;

  phase_t cur_phase   = PH_FREE;
  logic   item_taken  = 1'b0;
  int     accepted    = 0;
  int     total_items = 0;
  int     hold_cycles = 0;
  int     cycle_cnt   = 0;
  int     err_count   = 0;

  mono_last_note_priority_stack dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Apply one event to the note stack and return the voice result it causes
  function automatic voice_result_t play_event(logic op, logic [NOTE_W-1:0] key,
                                               logic [VEL_W-1:0] vel);
    voice_result_t res;
    int hit;
    res = '0;
    hit = -1;
    if (op == mlnps_pkg::OP_NOTE_ON) begin
      // Slide when something is already held, retrigger on a fresh note
      res.gate   = 1'b1;
      res.key    = key;
      res.vel    = vel;
      res.slide  = (stack_cnt > 0);
      res.retrig = (stack_cnt == 0);
      // A full stack drops the note but it still sounds
      if (stack_cnt < DEPTH) begin
        stack_key[stack_cnt] = key;
        stack_vel[stack_cnt] = vel;
        stack_cnt++;
      end
    end else begin
      // Remove only the oldest matching entry, shift later entries down
      for (int i = 0; i < stack_cnt; i++) begin
        if (hit < 0 && stack_key[i] == key) hit = i;
      end
      if (hit >= 0) begin
        for (int j = hit; j < stack_cnt - 1; j++) begin
          stack_key[j] = stack_key[j+1];
          stack_vel[j] = stack_vel[j+1];
        end
        stack_cnt--;
      end
      // Fall back to the most recent held note, or release the gate
      if (stack_cnt > 0) begin
        res.gate  = 1'b1;
        res.key   = stack_key[stack_cnt-1];
        res.vel   = stack_vel[stack_cnt-1];
        res.slide = 1'b1;
      end
    end
    res.held = TOTAL_W'(stack_cnt);
    return res;
  endfunction

  // Queue one item for the driver and track held notes for the generator
  function automatic void add_event(logic op, logic [NOTE_W-1:0] key,
                                    logic [VEL_W-1:0] vel, phase_t ph);
    note_event_t ev;
    ev.op  = op;
    ev.key = key;
    ev.vel = vel;
    ev.ph  = ph;
    pending_events.push_back(ev);
    total_items++;
    if (op == mlnps_pkg::OP_NOTE_ON) begin
      if (gen_held.size() < DEPTH) gen_held.push_back(key);
    end else begin
      for (int i = 0; i < gen_held.size(); i++) begin
        if (gen_held[i] == key) begin
          gen_held.delete(i);
          break;
        end
      end
    end
  endfunction

  // Stimulus and end of run
  initial begin
    phase_t            ph;
    logic              fill;
    logic [NOTE_W-1:0] pool[8];
    logic [NOTE_W-1:0] key;

    // Directed: note-off on an empty stack releases the gate
    add_event(mlnps_pkg::OP_NOTE_OFF, 7'd5, 7'd64, PH_FREE);
    // Zero note and zero velocity retrigger, extremes slide on top
    add_event(mlnps_pkg::OP_NOTE_ON, 7'd0, 7'd0, PH_FREE);
    add_event(mlnps_pkg::OP_NOTE_ON, 7'd127, 7'd127, PH_FREE);
    // Duplicate note: the off removes the older copy only
    add_event(mlnps_pkg::OP_NOTE_ON, 7'd0, 7'd85, PH_FREE);
    add_event(mlnps_pkg::OP_NOTE_OFF, 7'd0, 7'd127, PH_FREE);
    // Note-off for a note not held replays the top entry
    add_event(mlnps_pkg::OP_NOTE_OFF, 7'd99, 7'd0, PH_FREE);
    add_event(mlnps_pkg::OP_NOTE_OFF, 7'd0, 7'd42, PH_FREE);
    add_event(mlnps_pkg::OP_NOTE_OFF, 7'd127, 7'd21, PH_FREE);
    // Fill the stack, then one more note-on while full
    for (int i = 0; i <= DEPTH; i++) begin
      add_event(mlnps_pkg::OP_NOTE_ON, NOTE_W'(i * 8 + 3), VEL_W'(127 - i * 7), PH_FREE);
    end

    // Random phases: mostly plays on a small set of notes so that
    // duplicates, deep stacks and full stacks occur; alternate between
    // filling and draining runs
    fill = 1'b1;
    for (int p = 0; p < 5; p++) begin
      ph = phase_t'(p);
      foreach (pool[k]) pool[k] = NOTE_W'($urandom_range(127));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(39) == 0) fill = ~fill;
        if ($urandom_range(99) < (fill ? 75 : 25)) begin
          key = ($urandom_range(3) == 0) ? NOTE_W'($urandom_range(127))
                                         : pool[$urandom_range(7)];
          add_event(mlnps_pkg::OP_NOTE_ON, key, VEL_W'($urandom_range(127)), ph);
        end else if (gen_held.size() > 0 && $urandom_range(9) < 8) begin
          key = gen_held[$urandom_range(gen_held.size() - 1)];
          add_event(mlnps_pkg::OP_NOTE_OFF, key, VEL_W'($urandom_range(127)), ph);
        end else begin
          add_event(mlnps_pkg::OP_NOTE_OFF, NOTE_W'($urandom_range(127)),
                    VEL_W'($urandom_range(127)), ph);
        end
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Wait for every item to be taken and every result to arrive, then
    // keep watching the master stream for any stray result
    wait (accepted == total_items && expected_voice.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Sender: offer the next item on the falling edge, idle per phase
  always @(negedge clk) begin
    int unsigned idle_pct;
    note_event_t ev;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || item_taken) begin
      case (cur_phase)
        PH_SRC_IDLE:  idle_pct = 81;
        PH_BOTH_IDLE: idle_pct = 28;
        default:      idle_pct = 0;
      endcase
      if (pending_events.size() > 0 && $urandom_range(99) >= idle_pct) begin
        ev = pending_events.pop_front();
        s_tvalid  <= 1'b1;
        s_tuser   <= ev.op;
        s_tdata   <= {2'b00, ev.vel, ev.key};
        cur_phase <= ev.ph;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: hold off once for a long stretch in the pressure phase,
  // otherwise stall at random per phase
  always @(negedge clk) begin
    int unsigned stall_pct;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (cur_phase == PH_HOLD && hold_cycles < HOLD_LEN) begin
      hold_cycles <= hold_cycles + 1;
      m_tready    <= 1'b0;
    end else begin
      case (cur_phase)
        PH_SINK_STALL: stall_pct = 81;
        PH_BOTH_IDLE:  stall_pct = 28;
        default:       stall_pct = 0;
      endcase
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Predict on each accepted item, check each accepted result
  always @(posedge clk) begin
    voice_result_t exp_res;
    voice_result_t got;
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        expected_voice.push_back(play_event(s_tuser, s_tdata[6:0], s_tdata[13:7]));
        accepted <= accepted + 1;
      end
      if (m_tvalid && m_tready) begin
        got.gate   = m_tdata[0];
        got.key    = m_tdata[7:1];
        got.vel    = m_tdata[14:8];
        got.slide  = m_tdata[15];
        got.retrig = m_tdata[16];
        got.held   = m_tdata[21:17];
        if (expected_voice.size() == 0) begin
          $error("result with no item pending: m_tdata %h", m_tdata);
          err_count++;
        end else begin
          exp_res = expected_voice.pop_front();
          if (got.gate !== exp_res.gate) begin
            $error("gate expected %0d got %0d", exp_res.gate, got.gate);
            err_count++;
          end
          if (got.key !== exp_res.key) begin
            $error("sounding_note expected %0d got %0d", exp_res.key, got.key);
            err_count++;
          end
          if (got.vel !== exp_res.vel) begin
            $error("sounding_velocity expected %0d got %0d", exp_res.vel, got.vel);
            err_count++;
          end
          if (got.slide !== exp_res.slide) begin
            $error("slide expected %0d got %0d", exp_res.slide, got.slide);
            err_count++;
          end
          if (got.retrig !== exp_res.retrig) begin
            $error("retrigger expected %0d got %0d", exp_res.retrig, got.retrig);
            err_count++;
          end
          if (got.held !== exp_res.held) begin
            $error("held_total expected %0d got %0d", exp_res.held, got.held);
            err_count++;
          end
        end
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
